// ----- rtl/ax25_header_parser_unit_macros.svh -----
// Assertion macros for the AX.25 header parser RTL.
`ifndef AX25_HEADER_PARSER_UNIT_MACROS_SVH
`define AX25_HEADER_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define AHP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ahp assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define AHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ahp assertion failed");

`else

`define AHP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define AHP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/ahp_pkg.sv -----
// Shared types and constants of the AX.25 header parser.
`timescale 1ns / 1ps
`default_nettype none

package ahp_pkg;

    // Result record kinds
    localparam logic [1:0] KIND_ADDR    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // Frame end status codes
    localparam logic [2:0] STATUS_OK             = 3'd0;
    localparam logic [2:0] STATUS_SHORT          = 3'd1;
    localparam logic [2:0] STATUS_BAD_ADDR       = 3'd2;
    localparam logic [2:0] STATUS_TOO_MANY_DIGIS = 3'd3;
    localparam logic [2:0] STATUS_UNTERMINATED   = 3'd4;
    localparam logic [2:0] STATUS_MISSING_PID    = 3'd5;

    // Header field constants
    localparam int         CALL_CHARS      = 6;
    localparam logic [3:0] MIN_FRAME_BYTES = 4'd14;
    localparam logic [6:0] CHAR_SPACE      = 7'h20;
    localparam logic [7:0] SSID_FIXED_MASK = 8'h60;
    localparam logic [7:0] UI_MASK         = 8'hEF;
    localparam logic [7:0] UI_CONTROL      = 8'h03;

    // Command queue between parser front and record emitter
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One parsed byte: an optional address/payload record and an optional end record
    typedef struct packed {
        logic        rec_valid;
        logic [1:0]  rec_kind;
        logic [47:0] callsign;
        logic [2:0]  call_length;
        logic [3:0]  ssid;
        logic        repeated;
        logic [3:0]  address_index;
        logic [7:0]  payload_byte;
        logic        end_valid;
        logic [7:0]  control_field;
        logic [7:0]  pid_field;
        logic        pid_present;
        logic [2:0]  status;
    } rec_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/ax25_header_parser_unit.sv -----
// Top level of the streaming AX.25 frame header parser.
//
//  Channel | Direction | Ports                     | Transaction
//  --------+-----------+---------------------------+----------------------------------------
//  s_      | in        | s_valid/s_ready + fields  | one frame byte, end_of_frame on last
//  m_      | out       | m_valid/m_ready + fields  | address, payload or frame end record
//
//  Takes one byte per cycle while the command queue has room; the front parser updates
//  its header state as each byte is accepted. A record passes through the command queue
//  into the output register. The last byte of a frame may give two records, emitted one
//  after the other by the back end; the four-entry command queue absorbs that and short
//  output stalls. s_ready drops only while the command queue is full.
//  aresetn is synchronous and active low; it clears parse state, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none
`include "ax25_header_parser_unit_macros.svh"

module ax25_header_parser_unit #(
    parameter int MAX_DIGIS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // frame byte channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_frame_byte,
    input  wire logic        s_end_of_frame,

    // record channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_record_kind,
    output logic [47:0]      m_callsign,
    output logic [2:0]       m_call_length,
    output logic [3:0]       m_ssid,
    output logic             m_repeated,
    output logic [3:0]       m_address_index,
    output logic [7:0]       m_payload_byte,
    output logic [7:0]       m_control_field,
    output logic [7:0]       m_pid_field,
    output logic             m_pid_present,
    output logic [2:0]       m_status,
    output logic             m_last_of_run
);

    // Highest address index that can ever be emitted: destination, source, digis
    localparam logic [3:0] MAX_INDEX = 4'(MAX_DIGIS + 1);

    logic              q_ready;
    logic              q_valid;
    logic              push;
    logic              pop;
    ahp_pkg::rec_cmd_t push_cmd;
    ahp_pkg::rec_cmd_t head_cmd;

    // Front: accept each byte, classify it and build at most one command per byte
    ahp_front #(
        .MAX_DIGIS (MAX_DIGIS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_byte   (s_frame_byte),
        .s_end_of_frame (s_end_of_frame),
        .q_ready        (q_ready),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // Queue: decouple the byte rate from result back-pressure
    ahp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready),
        .q_valid  (q_valid),
        .head_cmd (head_cmd),
        .pop      (pop)
    );

    // Back: split each command into one or two result transactions
    ahp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .head_cmd        (head_cmd),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_record_kind   (m_record_kind),
        .m_callsign      (m_callsign),
        .m_call_length   (m_call_length),
        .m_ssid          (m_ssid),
        .m_repeated      (m_repeated),
        .m_address_index (m_address_index),
        .m_payload_byte  (m_payload_byte),
        .m_control_field (m_control_field),
        .m_pid_field     (m_pid_field),
        .m_pid_present   (m_pid_present),
        .m_status        (m_status),
        .m_last_of_run   (m_last_of_run)
    );

    // A frame end record always closes the run of its byte
    `AHP_ASSERT_SAME(a_end_is_last, aclk, aresetn, m_valid && (m_record_kind == ahp_pkg::KIND_END), m_last_of_run)

    // The digipeater limit bounds the address index
    `AHP_ASSERT_SAME(a_index_bound, aclk, aresetn, m_valid && (m_record_kind == ahp_pkg::KIND_ADDR), m_address_index <= MAX_INDEX)

    // Never pop an empty queue
    `AHP_ASSERT_SAME(a_pop_nonempty, aclk, aresetn, pop, q_valid)

    // The owed frame end record follows right after its companion record
    `AHP_ASSERT_NEXT(a_run_continues, aclk, aresetn, m_valid && m_ready && !m_last_of_run, m_valid && (m_record_kind == ahp_pkg::KIND_END))

endmodule

`default_nettype wire

// ----- rtl/ahp_front.sv -----
// Parser front: accepts frame bytes, tracks header state, builds record commands.
`timescale 1ns / 1ps
`default_nettype none

module ahp_front #(
    parameter int MAX_DIGIS = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_frame_byte,
    input  wire logic              s_end_of_frame,
    input  wire logic              q_ready,
    output logic                   push,
    output ahp_pkg::rec_cmd_t      push_cmd
);

    localparam logic [2:0] ST_ADDR    = 3'd0;
    localparam logic [2:0] ST_CONTROL = 3'd1;
    localparam logic [2:0] ST_PID     = 3'd2;
    localparam logic [2:0] ST_PAYLOAD = 3'd3;
    localparam logic [2:0] ST_SINK    = 3'd4;

    localparam logic [3:0] DIGI_LIMIT = 4'(MAX_DIGIS + 2);

    logic [2:0]  stage_reg, stage_next;
    logic [2:0]  byte_in_addr_reg, byte_in_addr_next;
    logic [3:0]  addr_count_reg, addr_count_next;
    logic        padding_reg, padding_next;
    logic [47:0] char_store_reg, char_store_next;
    logic [2:0]  char_count_reg, char_count_next;
    logic [3:0]  bytes_seen_reg, bytes_seen_next;
    logic [2:0]  first_error_reg, first_error_next;
    logic [7:0]  control_reg, control_next;
    logic        pid_flag_reg, pid_flag_next;
    logic [7:0]  pid_reg, pid_next;
    logic        addr_bad_reg, addr_bad_next;

    logic              accept;
    logic [6:0]        ch;
    logic              is_alnum;
    logic              ssid_bad;
    logic [2:0]        end_status;
    ahp_pkg::rec_cmd_t cmd;

    assign s_ready  = q_ready;
    assign accept   = s_valid && s_ready;
    assign ch       = s_frame_byte[7:1];
    assign is_alnum = (ch >= 7'h41 && ch <= 7'h5A) || (ch >= 7'h30 && ch <= 7'h39);
    assign ssid_bad = addr_bad_reg || (char_count_reg == 3'd0) ||
                      ((s_frame_byte & ahp_pkg::SSID_FIXED_MASK) != ahp_pkg::SSID_FIXED_MASK);

    always_comb begin
        stage_next        = stage_reg;
        byte_in_addr_next = byte_in_addr_reg;
        addr_count_next   = addr_count_reg;
        padding_next      = padding_reg;
        char_store_next   = char_store_reg;
        char_count_next   = char_count_reg;
        first_error_next  = first_error_reg;
        control_next      = control_reg;
        pid_flag_next     = pid_flag_reg;
        pid_next          = pid_reg;
        addr_bad_next     = addr_bad_reg;
        cmd               = '0;
        end_status        = ahp_pkg::STATUS_OK;

        bytes_seen_next = (bytes_seen_reg < ahp_pkg::MIN_FRAME_BYTES) ?
                          bytes_seen_reg + 4'd1 : bytes_seen_reg;

        unique case (stage_reg)
            ST_ADDR: begin
                if (byte_in_addr_reg < 3'd6) begin
                    // callsign character byte
                    if (s_frame_byte[0]) begin
                        addr_bad_next = 1'b1;
                    end else if (ch == ahp_pkg::CHAR_SPACE) begin
                        padding_next = 1'b1;
                    end else if (padding_reg || !is_alnum) begin
                        addr_bad_next = 1'b1;
                    end else if (char_count_reg < 3'd6) begin
                        for (int i = 0; i < ahp_pkg::CALL_CHARS; i++) begin
                            if (char_count_reg == 3'(i)) begin
                                char_store_next[i*8 +: 8] = {1'b0, ch};
                            end
                        end
                        char_count_next = char_count_reg + 3'd1;
                    end
                    byte_in_addr_next = byte_in_addr_reg + 3'd1;
                end else begin
                    // SSID byte closes the address
                    if (ssid_bad || (addr_count_reg == 4'd0 && s_frame_byte[0])) begin
                        if (first_error_reg == ahp_pkg::STATUS_OK) begin
                            first_error_next = ahp_pkg::STATUS_BAD_ADDR;
                        end
                        stage_next = ST_SINK;
                    end else begin
                        cmd.rec_valid     = 1'b1;
                        cmd.rec_kind      = ahp_pkg::KIND_ADDR;
                        cmd.callsign      = char_store_reg;
                        cmd.call_length   = char_count_reg;
                        cmd.ssid          = s_frame_byte[4:1];
                        cmd.repeated      = s_frame_byte[7];
                        cmd.address_index = addr_count_reg;
                        addr_count_next   = addr_count_reg + 4'd1;
                        if (s_frame_byte[0]) begin
                            stage_next = ST_CONTROL;
                        end else if (addr_count_next >= DIGI_LIMIT) begin
                            if (first_error_reg == ahp_pkg::STATUS_OK) begin
                                first_error_next = ahp_pkg::STATUS_TOO_MANY_DIGIS;
                            end
                            stage_next = ST_SINK;
                        end
                    end
                    byte_in_addr_next = 3'd0;
                    padding_next      = 1'b0;
                    char_store_next   = '0;
                    char_count_next   = 3'd0;
                    addr_bad_next     = 1'b0;
                end
            end
            ST_CONTROL: begin
                control_next  = s_frame_byte;
                pid_flag_next = !s_frame_byte[0] ||
                                ((s_frame_byte & ahp_pkg::UI_MASK) == ahp_pkg::UI_CONTROL);
                stage_next    = pid_flag_next ? ST_PID : ST_PAYLOAD;
            end
            ST_PID: begin
                pid_next   = s_frame_byte;
                stage_next = ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                cmd.rec_valid    = 1'b1;
                cmd.rec_kind     = ahp_pkg::KIND_PAYLOAD;
                cmd.payload_byte = s_frame_byte;
            end
            default: begin
                // drop bytes until the frame ends
            end
        endcase

        priority if (bytes_seen_next < ahp_pkg::MIN_FRAME_BYTES) begin
            end_status = ahp_pkg::STATUS_SHORT;
        end else if (first_error_next != ahp_pkg::STATUS_OK) begin
            end_status = first_error_next;
        end else if (stage_next == ST_ADDR) begin
            end_status = ahp_pkg::STATUS_UNTERMINATED;
        end else if (stage_next == ST_CONTROL) begin
            end_status = ahp_pkg::STATUS_SHORT;
        end else if (stage_next == ST_PID) begin
            end_status = ahp_pkg::STATUS_MISSING_PID;
        end else begin
            end_status = ahp_pkg::STATUS_OK;
        end

        if (s_end_of_frame) begin
            cmd.end_valid     = 1'b1;
            cmd.control_field = control_next;
            cmd.pid_field     = pid_next;
            cmd.pid_present   = pid_flag_next;
            cmd.status        = end_status;

            stage_next        = ST_ADDR;
            byte_in_addr_next = 3'd0;
            addr_count_next   = 4'd0;
            padding_next      = 1'b0;
            char_store_next   = '0;
            char_count_next   = 3'd0;
            bytes_seen_next   = 4'd0;
            first_error_next  = ahp_pkg::STATUS_OK;
            control_next      = 8'd0;
            pid_flag_next     = 1'b0;
            pid_next          = 8'd0;
            addr_bad_next     = 1'b0;
        end
    end

    assign push     = accept && (cmd.rec_valid || cmd.end_valid);
    assign push_cmd = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg        <= ST_ADDR;
            byte_in_addr_reg <= 3'd0;
            addr_count_reg   <= 4'd0;
            padding_reg      <= 1'b0;
            char_store_reg   <= '0;
            char_count_reg   <= 3'd0;
            bytes_seen_reg   <= 4'd0;
            first_error_reg  <= ahp_pkg::STATUS_OK;
            control_reg      <= 8'd0;
            pid_flag_reg     <= 1'b0;
            pid_reg          <= 8'd0;
            addr_bad_reg     <= 1'b0;
        end else if (accept) begin
            stage_reg        <= stage_next;
            byte_in_addr_reg <= byte_in_addr_next;
            addr_count_reg   <= addr_count_next;
            padding_reg      <= padding_next;
            char_store_reg   <= char_store_next;
            char_count_reg   <= char_count_next;
            bytes_seen_reg   <= bytes_seen_next;
            first_error_reg  <= first_error_next;
            control_reg      <= control_next;
            pid_flag_reg     <= pid_flag_next;
            pid_reg          <= pid_next;
            addr_bad_reg     <= addr_bad_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ahp_queue.sv -----
// Short command queue between the parser front and the record emitter.
`timescale 1ns / 1ps
`default_nettype none

module ahp_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire ahp_pkg::rec_cmd_t push_cmd,
    output logic                   q_ready,
    output logic                   q_valid,
    output ahp_pkg::rec_cmd_t      head_cmd,
    input  wire logic              pop
);

    ahp_pkg::rec_cmd_t               mem_reg [ahp_pkg::QUEUE_DEPTH];
    logic [ahp_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ahp_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [ahp_pkg::QCNT_W-1:0]      count_reg, count_next;

    assign q_ready  = (count_reg != ahp_pkg::QCNT_W'(ahp_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + ahp_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + ahp_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + ahp_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - ahp_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ahp_back.sv -----
// Record emitter: unpacks queued commands into result transactions.
`timescale 1ns / 1ps
`default_nettype none

module ahp_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire ahp_pkg::rec_cmd_t head_cmd,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_record_kind,
    output logic [47:0]            m_callsign,
    output logic [2:0]             m_call_length,
    output logic [3:0]             m_ssid,
    output logic                   m_repeated,
    output logic [3:0]             m_address_index,
    output logic [7:0]             m_payload_byte,
    output logic [7:0]             m_control_field,
    output logic [7:0]             m_pid_field,
    output logic                   m_pid_present,
    output logic [2:0]             m_status,
    output logic                   m_last_of_run
);

    logic        valid_reg, valid_next;
    logic        phase_reg, phase_next;   // 1: record sent, end record still owed
    logic        out_free;
    logic        load;
    logic        send_rec;

    logic [1:0]  kind_reg;
    logic [47:0] callsign_reg;
    logic [2:0]  call_length_reg;
    logic [3:0]  ssid_reg;
    logic        repeated_reg;
    logic [3:0]  address_index_reg;
    logic [7:0]  payload_byte_reg;
    logic [7:0]  control_reg;
    logic [7:0]  pid_reg;
    logic        pid_present_reg;
    logic [2:0]  status_reg;
    logic        last_reg;

    assign out_free = !valid_reg || m_ready;
    assign load     = out_free && q_valid;
    assign send_rec = !phase_reg && head_cmd.rec_valid;

    always_comb begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (send_rec && head_cmd.end_valid) begin
                phase_next = 1'b1;
            end else begin
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end else if (out_free) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (send_rec) begin
                kind_reg          <= head_cmd.rec_kind;
                callsign_reg      <= head_cmd.callsign;
                call_length_reg   <= head_cmd.call_length;
                ssid_reg          <= head_cmd.ssid;
                repeated_reg      <= head_cmd.repeated;
                address_index_reg <= head_cmd.address_index;
                payload_byte_reg  <= head_cmd.payload_byte;
                control_reg       <= 8'd0;
                pid_reg           <= 8'd0;
                pid_present_reg   <= 1'b0;
                status_reg        <= ahp_pkg::STATUS_OK;
                last_reg          <= !head_cmd.end_valid;
            end else begin
                kind_reg          <= ahp_pkg::KIND_END;
                callsign_reg      <= '0;
                call_length_reg   <= 3'd0;
                ssid_reg          <= 4'd0;
                repeated_reg      <= 1'b0;
                address_index_reg <= 4'd0;
                payload_byte_reg  <= 8'd0;
                control_reg       <= head_cmd.control_field;
                pid_reg           <= head_cmd.pid_field;
                pid_present_reg   <= head_cmd.pid_present;
                status_reg        <= head_cmd.status;
                last_reg          <= 1'b1;
            end
        end
    end

    assign m_valid         = valid_reg;
    assign m_record_kind   = kind_reg;
    assign m_callsign      = callsign_reg;
    assign m_call_length   = call_length_reg;
    assign m_ssid          = ssid_reg;
    assign m_repeated      = repeated_reg;
    assign m_address_index = address_index_reg;
    assign m_payload_byte  = payload_byte_reg;
    assign m_control_field = control_reg;
    assign m_pid_field     = pid_reg;
    assign m_pid_present   = pid_present_reg;
    assign m_status        = status_reg;
    assign m_last_of_run   = last_reg;

endmodule

`default_nettype wire
